// ===== src/assert_macros.svh =====
// Assertion macros used by irq_latency_histogram.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define ILH_ASSERT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("irq_latency_histogram: assertion failed");

// Next-cycle implication, checked out of reset.
`define ILH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("irq_latency_histogram: assertion failed");

`else

`define ILH_ASSERT(lbl, clk, rst_n, ante, cons)
`define ILH_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/ilh_pkg.sv =====
// Types, constants and helpers of the interrupt latency histogram.
package ilh_pkg;

  localparam int TS_W    = 32;
  localparam int US_W    = 20;
  localparam int ACC_W   = TS_W + US_W;
  localparam int IDX_W   = 12;
  localparam int STEP_W  = 5;

  localparam logic [US_W-1:0]   US_PER_SEC     = US_W'(1000000);
  localparam logic [TS_W-1:0]   CLOCK_HZ_RESET = TS_W'(100000000);
  localparam logic [STEP_W-1:0] MUL_LAST       = STEP_W'(US_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST       = STEP_W'(TS_W - 1);

  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [TS_W-1:0]  start_time;
    logic [TS_W-1:0]  now_time;
    logic [IDX_W-1:0] bin_index;
  } in_t;

  typedef struct packed {
    logic [TS_W-1:0] latency_us;
    logic            was_missed;
    logic [TS_W-1:0] bin_count;
    logic [TS_W-1:0] handled_total;
    logic [TS_W-1:0] missed_total;
  } out_t;

  typedef logic [TS_W-1:0] cfg_t;

  // Saturating increment, sticks at all ones.
  function automatic logic [TS_W-1:0] sat_inc(input logic [TS_W-1:0] v);
    sat_inc = (v == {TS_W{1'b1}}) ? v : v + TS_W'(1);
  endfunction

endpackage

// ===== src/ilh_stream_if.sv =====
// Valid/ready channel carrying one payload item per transfer.
interface ilh_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/irq_latency_histogram.sv =====
// Interrupt latency histogram: after reset the block sweeps the bin memory to zero, one bin
// per cycle, with in_ch.ready low (clock_hz writes are taken meanwhile). A read request
// goes from S_IDLE to S_DONE, which registers its result once the output register is free.
// A record request runs a bit-serial multiply by 1000000 and a restoring divide by clock_hz
// (skipped when the result saturates), then, when the latency lands in a bin, a bin
// read-modify-write; its result is registered in S_DONE and the next item is taken in
// S_IDLE after that. One item is in flight at a time; a finished result waits in the output
// register and does not hold off the next input transfer.
`include "assert_macros.svh"

module irq_latency_histogram #(
  parameter int NUM_BINS = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  ilh_stream_if.sink   in_ch,
  ilh_stream_if.source out_ch,
  ilh_stream_if.sink   cfg_ch
);

  localparam int BIN_W = $clog2(NUM_BINS);
  localparam int TS_W  = ilh_pkg::TS_W;
  localparam int ACC_W = ilh_pkg::ACC_W;
  localparam logic [BIN_W-1:0] CLR_LAST  = BIN_W'(NUM_BINS - 1);
  localparam logic [TS_W-1:0]  BINS_TS   = TS_W'(NUM_BINS);

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_CHK  = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_POST = 8'b0010_0000,
    S_WR   = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [ilh_pkg::STEP_W-1:0]   cnt_r, cnt_nxt;
  logic [BIN_W-1:0]             clr_r, clr_nxt;
  logic [TS_W-1:0]              ticks_r, ticks_nxt;
  logic [ACC_W-1:0]             acc_r, acc_nxt;
  logic [TS_W-1:0]              rem_r, rem_nxt;
  logic                         req_r, req_nxt;
  logic                         idx_ok_r, idx_ok_nxt;
  logic                         miss_r, miss_nxt;
  logic [TS_W-1:0]              hz_r, hz_nxt;
  logic [TS_W-1:0]              handled_r, handled_nxt;
  logic [TS_W-1:0]              missed_r, missed_nxt;
  logic                         out_valid_r, out_valid_nxt;
  ilh_pkg::out_t                out_r, out_nxt;

  logic [TS_W-1:0]              hist_mem [NUM_BINS];
  logic [TS_W-1:0]              rd_data_r;
  logic                         mem_rd_en;
  logic [BIN_W-1:0]             mem_rd_addr;
  logic                         mem_we;
  logic [BIN_W-1:0]             mem_wa;
  logic [TS_W-1:0]              mem_wd;

  logic                         in_acc;
  logic [TS_W-1:0]              in_idx_ts;
  logic [ilh_pkg::STEP_W-1:0]   mul_idx;
  logic                         mul_bit;
  logic [TS_W:0]                div_trial;
  logic                         div_ge;
  logic [TS_W:0]                div_diff;
  logic                         lat_in_range;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  assign in_idx_ts    = TS_W'(in_ch.data.bin_index);
  assign mul_idx      = ilh_pkg::MUL_LAST - cnt_r;
  assign mul_bit      = ilh_pkg::US_PER_SEC[mul_idx];
  // Shift one dividend bit into the partial remainder.
  assign div_trial    = {rem_r, acc_r[TS_W-1]};
  assign div_ge       = (div_trial >= {1'b0, hz_r});
  assign div_diff     = div_trial - {1'b0, hz_r};
  assign lat_in_range = (acc_r[TS_W-1:0] < BINS_TS);

  // Bin memory port control
  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = acc_r[BIN_W-1:0];
    mem_we      = 1'b0;
    mem_wa      = acc_r[BIN_W-1:0];
    mem_wd      = ilh_pkg::sat_inc(rd_data_r);
    if (state_r == S_IDLE) begin
      mem_rd_en   = in_acc;
      mem_rd_addr = in_idx_ts[BIN_W-1:0];
    end
    if (state_r == S_POST) begin
      mem_rd_en = lat_in_range;
    end
    if (state_r == S_CLR) begin
      mem_we = 1'b1;
      mem_wa = clr_r;
      mem_wd = '0;
    end
    if (state_r == S_WR) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd_en) begin
      rd_data_r <= hist_mem[mem_rd_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    clr_nxt       = clr_r;
    ticks_nxt     = ticks_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    req_nxt       = req_r;
    idx_ok_nxt    = idx_ok_r;
    miss_nxt      = miss_r;
    handled_nxt   = handled_r;
    missed_nxt    = missed_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    hz_nxt        = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.data : hz_r;

    unique case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + BIN_W'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          req_nxt    = in_ch.data.req_type;
          ticks_nxt  = in_ch.data.now_time - in_ch.data.start_time;
          idx_ok_nxt = (in_idx_ts < BINS_TS);
          acc_nxt    = '0;
          cnt_nxt    = '0;
          miss_nxt   = 1'b0;
          state_nxt  = (in_ch.data.req_type == ilh_pkg::REQ_READ) ? S_DONE : S_MUL;
        end
      end
      S_MUL: begin
        // MSB-first shift-and-add over the bits of the constant
        acc_nxt = {acc_r[ACC_W-2:0], 1'b0} + (mul_bit ? ACC_W'(ticks_r) : '0);
        cnt_nxt = cnt_r + ilh_pkg::STEP_W'(1);
        if (cnt_r == ilh_pkg::MUL_LAST) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        // Quotient reaches 2^32 exactly when the upper product bits reach the divisor;
        // a zero clock lands here too.
        rem_nxt = TS_W'(acc_r[ACC_W-1:TS_W]);
        cnt_nxt = '0;
        if (TS_W'(acc_r[ACC_W-1:TS_W]) >= hz_r) begin
          acc_nxt[TS_W-1:0] = '1;
          state_nxt         = S_POST;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt           = div_ge ? div_diff[TS_W-1:0] : div_trial[TS_W-1:0];
        acc_nxt[TS_W-1:0] = {acc_r[TS_W-2:0], div_ge};
        cnt_nxt           = cnt_r + ilh_pkg::STEP_W'(1);
        if (cnt_r == ilh_pkg::DIV_LAST) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        handled_nxt = ilh_pkg::sat_inc(handled_r);
        if (lat_in_range) begin
          state_nxt = S_WR;
        end else begin
          miss_nxt   = 1'b1;
          missed_nxt = ilh_pkg::sat_inc(missed_r);
          state_nxt  = S_DONE;
        end
      end
      S_WR: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt         = 1'b1;
          out_nxt.latency_us    = (req_r == ilh_pkg::REQ_READ) ? '0 : acc_r[TS_W-1:0];
          out_nxt.was_missed    = miss_r;
          out_nxt.bin_count     = (req_r == ilh_pkg::REQ_READ && idx_ok_r) ? rd_data_r : '0;
          out_nxt.handled_total = handled_r;
          out_nxt.missed_total  = missed_r;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      clr_r       <= '0;
      hz_r        <= ilh_pkg::CLOCK_HZ_RESET;
      handled_r   <= '0;
      missed_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_r       <= clr_nxt;
      hz_r        <= hz_nxt;
      handled_r   <= handled_nxt;
      missed_r    <= missed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ticks_r  <= ticks_nxt;
    acc_r    <= acc_nxt;
    rem_r    <= rem_nxt;
    req_r    <= req_nxt;
    idx_ok_r <= idx_ok_nxt;
    miss_r   <= miss_nxt;
    out_r    <= out_nxt;
  end

  `ILH_ASSERT(a_mem_we_state, clk, rst_n, mem_we, state_r == S_CLR || state_r == S_WR)
  `ILH_ASSERT(a_wr_in_range, clk, rst_n, state_r == S_WR, lat_in_range)
  `ILH_ASSERT(a_missed_out_range, clk, rst_n, out_valid_r && out_r.was_missed, out_r.latency_us >= BINS_TS)
  `ILH_ASSERT_NXT(a_div_to_post, clk, rst_n, state_r == S_DIV && cnt_r == ilh_pkg::DIV_LAST, state_r == S_POST)

endmodule
